/* design/dsv_pkg.sv */
// Shared constants, types and calendar tables of the date span and validity unit.
`timescale 1ns / 1ps

package dsv_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned DoyW = 9;
  localparam int unsigned LeapCntW = 13;
  localparam int unsigned SpanW = 23;

  localparam int unsigned YearMin = 2000;
  localparam int unsigned YearMax = 9999;

  // Reciprocals for division by 100 (shift 19) and by 25 (shift 15).
  localparam int unsigned Recip100 = 5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned Recip25 = 1311;
  localparam int unsigned Recip25Shift = 15;

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonMar = 4'd3;
  localparam logic [3:0] MonApr = 4'd4;
  localparam logic [3:0] MonMay = 4'd5;
  localparam logic [3:0] MonJun = 4'd6;
  localparam logic [3:0] MonJul = 4'd7;
  localparam logic [3:0] MonAug = 4'd8;
  localparam logic [3:0] MonSep = 4'd9;
  localparam logic [3:0] MonOct = 4'd10;
  localparam logic [3:0] MonNov = 4'd11;
  localparam logic [3:0] MonDec = 4'd12;

  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
  } stage_en_t;

  typedef struct packed {
    logic                ok;
    logic [YearW-1:0]    year;
    logic [DoyW-1:0]     doy;
    logic [LeapCntW-1:0] leap_cnt;
  } date_res_t;

  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] mon, logic leap);
    logic [DayW-1:0] len;
    case (mon)
      MonFeb: len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DoyW-1:0] days_before(logic [MonthW-1:0] mon);
    logic [DoyW-1:0] n;
    case (mon)
      MonJan: n = 9'd0;
      MonFeb: n = 9'd31;
      MonMar: n = 9'd59;
      MonApr: n = 9'd90;
      MonMay: n = 9'd120;
      MonJun: n = 9'd151;
      MonJul: n = 9'd181;
      MonAug: n = 9'd212;
      MonSep: n = 9'd243;
      MonOct: n = 9'd273;
      MonNov: n = 9'd304;
      MonDec: n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

/* design/dsv_date_eval.sv */
// Two pipeline stages that check one date and derive its ordinal day and leap count.
`timescale 1ns / 1ps

module dsv_date_eval import dsv_pkg::*; (
  input  logic                clk_i,
  input  stage_en_t           en_i,
  input  logic [YearW-1:0]    year_i,
  input  logic [MonthW-1:0]   month_i,
  input  logic [DayW-1:0]     day_i,
  output date_res_t           res_o
);

  logic [YearW-1:0]  yoff;
  logic [YearW:0]    x4;
  logic [YearW:0]    x100;
  logic [YearW:0]    x400;
  logic [10:0]       s400;

  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;
  logic              in_range_q, in_range_d;
  logic [26:0]       prod100_q, prod100_d;
  logic [27:0]       p100c_q, p100c_d;
  logic [21:0]       p400c_q, p400c_d;
  logic [12:0]       q4c_q, q4c_d;

  logic [7:0]        q100;
  logic [YearW-1:0]  r100;
  logic [7:0]        q100c;
  logic [5:0]        q400c;
  logic              leap;
  logic              valid_date;
  date_res_t         res_q, res_d;

  assign yoff = year_i - YearW'(YearMin);
  assign x4   = {1'b0, yoff} + 15'd3;
  assign x100 = {1'b0, yoff} + 15'd99;
  assign x400 = {1'b0, yoff} + 15'd399;
  assign s400 = x400[14:4];

  assign in_range_d = (year_i >= YearW'(YearMin)) && (year_i <= YearW'(YearMax));
  assign prod100_d  = 27'(year_i) * 27'(Recip100);
  assign p100c_d    = 28'(x100) * 28'(Recip100);
  assign p400c_d    = 22'(s400) * 22'(Recip25);
  assign q4c_d      = x4[14:2];

  always_ff @(posedge clk_i) begin
    if (en_i.en_a) begin
      year_q     <= year_i;
      month_q    <= month_i;
      day_q      <= day_i;
      in_range_q <= in_range_d;
      prod100_q  <= prod100_d;
      p100c_q    <= p100c_d;
      p400c_q    <= p400c_d;
      q4c_q      <= q4c_d;
    end
  end

  assign q100  = prod100_q[Recip100Shift+7:Recip100Shift];
  assign r100  = year_q - YearW'(14'(q100) * 14'd100);
  assign q100c = p100c_q[Recip100Shift+7:Recip100Shift];
  assign q400c = p400c_q[Recip25Shift+5:Recip25Shift];
  assign leap  = (year_q[1:0] == 2'b00) && ((r100 != '0) || (q100[1:0] == 2'b00));

  assign valid_date = in_range_q && (day_q != '0) && (day_q <= month_len(month_q, leap));

  always_comb begin
    res_d.ok       = valid_date;
    res_d.year     = year_q;
    res_d.doy      = days_before(month_q) + DoyW'(day_q)
                   + DoyW'((month_q > MonFeb) && leap);
    res_d.leap_cnt = q4c_q - LeapCntW'(q100c) + LeapCntW'(q400c);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* design/dsv_span_calc.sv */
// Final stage that forms the inclusive day span and registers the result.
`timescale 1ns / 1ps

module dsv_span_calc import dsv_pkg::*; (
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  date_res_t        start_i,
  input  date_res_t        end_i,
  output logic             start_ok_o,
  output logic             end_ok_o,
  output logic [SpanW-1:0] day_span_o
);

  logic signed [YearW:0]  year_diff;
  logic signed [24:0]     years_days;
  logic signed [24:0]     leap_corr;
  logic signed [24:0]     span_w;
  logic [LeapCntW-1:0]    leap_diff;
  logic                   start_ok_q;
  logic                   end_ok_q;
  logic [SpanW-1:0]       span_q, span_d;

  assign year_diff  = $signed({1'b0, end_i.year}) - $signed({1'b0, start_i.year});
  assign years_days = 25'(year_diff) * 25'sd365;
  assign leap_diff  = end_i.leap_cnt - start_i.leap_cnt;
  assign leap_corr  = (end_i.year > start_i.year) ? $signed(25'(leap_diff)) : 25'sd0;

  assign span_w = years_days + $signed(25'(end_i.doy)) - $signed(25'(start_i.doy))
                + 25'sd1 + leap_corr;

  assign span_d = (start_i.ok && end_i.ok) ? span_w[SpanW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (en_i.en_c) begin
      start_ok_q <= start_i.ok;
      end_ok_q   <= end_i.ok;
      span_q     <= span_d;
    end
  end

  assign start_ok_o = start_ok_q;
  assign end_ok_o   = end_ok_q;
  assign day_span_o = span_q;

endmodule

/* design/date_span_and_validity_unit.sv */
// Date span and validity unit: three-stage pipeline checking two dates and counting days.
// An accepted request enters stage a, then moves through stages b and c to the output.
// Throughput is one request per cycle while the output is not stalled; the three register stages set the depth.
// An output stall holds the full stages at the end of the pipeline; bubbles ahead close up.
// Reset clears the stage valid bits only, so the pipeline starts empty.
`timescale 1ns / 1ps

module date_span_and_validity_unit import dsv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [YearW-1:0]   start_year_i,
  input  logic [MonthW-1:0]  start_month_i,
  input  logic [DayW-1:0]    start_day_i,
  input  logic [YearW-1:0]   end_year_i,
  input  logic [MonthW-1:0]  end_month_i,
  input  logic [DayW-1:0]    end_day_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               start_ok_o,
  output logic               end_ok_o,
  output logic [SpanW-1:0]   day_span_o
);

  logic      va_q, vb_q, vc_q;
  logic      ready_a, ready_b, ready_c;
  stage_en_t en;
  date_res_t start_res;
  date_res_t end_res;

  assign ready_c = !vc_q || !out_stall_i;
  assign ready_b = !vb_q || ready_c;
  assign ready_a = !va_q || ready_b;

  assign en.en_a = ready_a;
  assign en.en_b = ready_b;
  assign en.en_c = ready_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= in_valid_i;
      if (ready_b) vb_q <= va_q;
      if (ready_c) vc_q <= vb_q;
    end
  end

  dsv_date_eval u_start (
    .clk_i   (clk_i),
    .en_i    (en),
    .year_i  (start_year_i),
    .month_i (start_month_i),
    .day_i   (start_day_i),
    .res_o   (start_res)
  );

  dsv_date_eval u_end (
    .clk_i   (clk_i),
    .en_i    (en),
    .year_i  (end_year_i),
    .month_i (end_month_i),
    .day_i   (end_day_i),
    .res_o   (end_res)
  );

  dsv_span_calc u_span (
    .clk_i      (clk_i),
    .en_i       (en),
    .start_i    (start_res),
    .end_i      (end_res),
    .start_ok_o (start_ok_o),
    .end_ok_o   (end_ok_o),
    .day_span_o (day_span_o)
  );

  assign in_stall_o  = !ready_a;
  assign out_valid_o = vc_q;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (va_q && vb_q && vc_q))
    else $error("input stalled while the pipeline has an empty stage");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> va_q)
    else $error("accepted request did not reach the first stage");

  a_advance_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && ready_c) |=> out_valid_o)
    else $error("request in the second stage was lost on its way to the output");

  a_invalid_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(start_ok_o && end_ok_o)) |-> (day_span_o == '0))
    else $error("non-zero span reported for an invalid date");
`endif

endmodule
